// ===== sv/mrr_pkg.sv =====
// shared types, constants and the crc-16 byte update for the modbus response receiver
// no dependencies; imported by every module of the block
`default_nettype none

package mrr_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int POS_W        = $clog2(BUFFER_BYTES + 1);
    localparam int HEADER_BYTES = 3;
    localparam int MIN_FRAME    = 5;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0] STATUS_SHORT   = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic             result_kind;
        logic [7:0]       data_value;
        logic [IDX_W-1:0] data_index;
        logic [7:0]       function_code;
        logic [CNT_W-1:0] byte_count;
        logic [1:0]       frame_status;
        logic [CNT_W-1:0] frame_length;
        logic             last_result;
    } out_item_t;

    // results made by one request, data result first
    typedef struct packed {
        logic [1:0] num;
        out_item_t  first;
        out_item_t  second;
    } push_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mrr_frame.sv =====
// frame tracker: address hunt, header capture, crc and result generation per request
// depends on mrr_pkg
`default_nettype none

module mrr_frame (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      cfg_wr_en,
    input  wire  [7:0]               cfg_wr_data,
    input  wire                      advance,
    input  wire  mrr_pkg::in_item_t  item,
    output mrr_pkg::push_t           push
);
    import mrr_pkg::*;

    logic [7:0]       addr_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       func_reg, func_next;
    logic [POS_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      tail_reg, tail_next;

    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] idx_full;
    logic [POS_W:0]   data_end;
    logic             data_hit;
    logic             done;
    logic [7:0]       b;
    out_item_t        status_item;
    out_item_t        data_item;

    function automatic out_item_t make_status(
        input logic [POS_W-1:0] len,
        input logic [15:0]      crc,
        input logic [15:0]      tail,
        input logic [7:0]       func,
        input logic [POS_W-1:0] cnt
    );
        out_item_t r;
        r = '0;
        r.result_kind   = KIND_STATUS;
        r.function_code = func;
        r.byte_count    = CNT_W'(cnt);
        r.frame_length  = CNT_W'(len);
        r.last_result   = 1'b1;
        if (len < POS_W'(MIN_FRAME)) begin
            r.frame_status = STATUS_SHORT;
        end else if (tail == {crc[7:0], crc[15:8]}) begin
            r.frame_status = STATUS_OK;
        end else begin
            r.frame_status = STATUS_CRC_ERR;
        end
        return r;
    endfunction

    assign b        = item.rx_byte;
    assign pos_inc  = pos_reg + POS_W'(1);
    assign idx_full = pos_reg - POS_W'(HEADER_BYTES);

    always_comb begin
        pos_next    = pos_reg;
        func_next   = func_reg;
        cnt_next    = cnt_reg;
        crc_next    = crc_reg;
        tail_next   = tail_reg;
        push        = '0;
        data_end    = {1'b0, cnt_reg} + (POS_W+1)'(HEADER_BYTES);
        data_hit    = 1'b0;
        done        = 1'b0;
        status_item = '0;
        data_item   = '0;
        if (advance) begin
            if (item.opcode == OP_TIMEOUT) begin
                push.num   = 2'd1;
                push.first = make_status(pos_reg, crc_reg, tail_reg, func_reg, cnt_reg);
                pos_next   = '0;
                func_next  = '0;
                cnt_next   = '0;
                crc_next   = CRC_INIT;
                tail_next  = '0;
            end else if (pos_reg == '0 && b != addr_reg) begin
                // hunting: drop the byte
            end else if (pos_reg == POS_W'(2) && {1'b0, b} > 9'(BUFFER_BYTES)) begin
                // announced count does not fit, hunt again
                pos_next  = '0;
                func_next = '0;
                cnt_next  = '0;
                crc_next  = CRC_INIT;
                tail_next = '0;
            end else begin
                if (pos_reg >= POS_W'(2)) begin
                    crc_next = crc_feed(crc_reg, tail_reg[15:8]);
                end
                tail_next = {tail_reg[7:0], b};
                if (pos_reg == POS_W'(1)) begin
                    func_next = b;
                end else if (pos_reg == POS_W'(2)) begin
                    cnt_next = POS_W'(b);
                end else if (pos_reg >= POS_W'(HEADER_BYTES)) begin
                    if ({1'b0, pos_reg} < data_end) begin
                        data_hit = 1'b1;
                    end else if ({1'b0, pos_reg} > data_end) begin
                        done = 1'b1;
                    end
                end
                pos_next = pos_inc;

                data_item.result_kind   = KIND_DATA;
                data_item.data_value    = b;
                data_item.data_index    = IDX_W'(idx_full);
                data_item.function_code = func_next;
                data_item.byte_count    = CNT_W'(cnt_next);
                status_item = make_status(pos_inc, crc_next, tail_next, func_next, cnt_next);

                if (done || {1'b0, pos_inc} >= (POS_W+1)'(BUFFER_BYTES)) begin
                    pos_next  = '0;
                    func_next = '0;
                    cnt_next  = '0;
                    crc_next  = CRC_INIT;
                    tail_next = '0;
                    if (data_hit) begin
                        push.num    = 2'd2;
                        push.first  = data_item;
                        push.second = status_item;
                    end else begin
                        push.num   = 2'd1;
                        push.first = status_item;
                    end
                end else if (data_hit) begin
                    push.num   = 2'd1;
                    push.first = data_item;
                    push.first.last_result = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= 8'd1;
            pos_reg  <= '0;
            func_reg <= '0;
            cnt_reg  <= '0;
            crc_reg  <= CRC_INIT;
            tail_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                addr_reg <= cfg_wr_data;
            end
            pos_reg  <= pos_next;
            func_reg <= func_next;
            cnt_reg  <= cnt_next;
            crc_reg  <= crc_next;
            tail_reg <= tail_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mrr_out_fifo.sv =====
// result queue: takes one or two results a cycle, hands out one per request
// depends on mrr_pkg
`default_nettype none

module mrr_out_fifo (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire  mrr_pkg::push_t     push,
    output logic                     room,
    output logic                     m_valid,
    input  wire                      m_ready,
    output mrr_pkg::out_item_t       m_data
);
    import mrr_pkg::*;

    out_item_t             entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_plus1;
    logic                  pop;

    // at most two results per request, so keep two slots free before taking one
    assign room         = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign m_valid      = count_reg != '0;
    assign m_data       = entry_reg[rd_ptr_reg];
    assign pop          = m_valid && m_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.num);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push.num) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/modbus_response_receiver.sv =====
// Modbus RTU response receiver. Takes one received byte or timeout event per
// cycle and returns the frame's data bytes and one end-of-frame status with the
// CRC-16 check. An accepted request is held in an input register; once the queue
// has room it runs through the frame tracker into a four-entry result queue, and
// the result is registered there before m_valid shows it. Requests are taken
// every cycle while the queue holds two results or fewer; a byte that yields both
// a data result and a status hands them out one after the other, and m_ready low
// backs up into s_ready through the queue.
// depends on mrr_pkg, mrr_frame, mrr_out_fifo
`default_nettype none

module modbus_response_receiver (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      cfg_wr_en,
    input  wire  [7:0]               cfg_wr_data,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire  mrr_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire                      m_ready,
    output mrr_pkg::out_item_t       m_data
);
    import mrr_pkg::*;

    logic     in_valid_reg;
    in_item_t in_item_reg;
    logic     room;
    logic     advance;
    push_t    push;

    assign advance = in_valid_reg && room;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
    end

    mrr_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .item        (in_item_reg),
        .push        (push)
    );

    mrr_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
